// ----- src/gcd_pkg.sv -----
package gcd_pkg;

  // Pipeline depths
  localparam int CORDIC_STAGES = 32;
  localparam int SQRT_STEPS    = 31;
  localparam int SQRT_TOP      = 60;

  // Datapath widths
  localparam int ANG_W    = 44;  // angle, Q40
  localparam int VEC_W    = 34;  // vector component, Q30
  localparam int SQ_W     = 63;  // root operand and partial root
  localparam int ROOT_W   = 31;  // square root result, Q30
  localparam int NLANE    = 4;   // rotation lanes
  localparam int SQ_LANES = 2;   // root lanes

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic [SQ_W-1:0]         sq_t;

  // Configuration register indexes
  localparam logic REG_EARTH_RADIUS = 1'b0;
  localparam logic REG_UNIT_SELECT  = 1'b1;

  localparam logic [23:0] RADIUS_RESET = 24'd6371000;
  localparam logic [33:0] KM_TO_M      = 34'd1000;

  // Angle scale: pi * 2^62 / 3.6e9, rounded
  localparam logic signed [32:0] ANG_SCALE_S = 33'sd4024455254;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'd3622009729038561421;
  localparam vec_t CORDIC_K_Q30 = 34'sd652032874;

  // Angle thresholds in half-units of 5e-8 degree
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1800000000;
  localparam logic signed [33:0] HALF_TURN    = 34'sd3600000000;

  localparam logic signed [68:0] ONE_Q60  = 69'sd1152921504606846976;
  localparam logic [39:0]        DIST_MAX = 40'h07_FFFF_FFFF;

  // Shift-and-subtract division, used only on constants at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) in Q40, from the alternating series in Q62.
  function automatic ang_t atan_q40(input int i);
    logic [63:0] acc;
    logic [63:0] t;
    int e;
    acc = '0;
    if (i == 0) begin
      return ang_t'((QUARTER_PI_Q62 + 64'd2097152) >> 22);
    end
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) acc = acc - t;
        else acc = acc + t;
      end
    end
    return ang_t'((acc + 64'd2097152) >> 22);
  endfunction

endpackage

// ----- src/gcd_cordic_rot.sv -----
module gcd_cordic_rot
  import gcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ang_t             z_in [NLANE],
  input  logic [NLANE-1:0] tag_in,
  output vec_t             x_out [NLANE],
  output vec_t             y_out [NLANE],
  output logic [NLANE-1:0] tag_out,
  output logic             out_valid
);

  vec_t             x_r [CORDIC_STAGES][NLANE];
  vec_t             y_r [CORDIC_STAGES][NLANE];
  ang_t             z_r [CORDIC_STAGES][NLANE];
  logic [NLANE-1:0] t_r [CORDIC_STAGES];
  logic             v_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    localparam ang_t ATAN = atan_q40(i);
    vec_t             xi [NLANE];
    vec_t             yi [NLANE];
    ang_t             zi [NLANE];
    logic [NLANE-1:0] ti;
    logic             vi;

    if (i == 0) begin : g_src
      assign xi = '{default: CORDIC_K_Q30};
      assign yi = '{default: '0};
      assign zi = z_in;
      assign ti = tag_in;
      assign vi = in_valid;
    end else begin : g_src
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ti = t_r[i-1];
      assign vi = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    // Rotate toward zero residual angle.
    always_ff @(posedge clk) begin
      if (en) begin
        t_r[i] <= ti;
        for (int l = 0; l < NLANE; l++) begin
          if (!zi[l][ANG_W-1]) begin
            x_r[i][l] <= xi[l] - (yi[l] >>> i);
            y_r[i][l] <= yi[l] + (xi[l] >>> i);
            z_r[i][l] <= zi[l] - ATAN;
          end else begin
            x_r[i][l] <= xi[l] + (yi[l] >>> i);
            y_r[i][l] <= yi[l] - (xi[l] >>> i);
            z_r[i][l] <= zi[l] + ATAN;
          end
        end
      end
    end
  end

  assign x_out     = x_r[CORDIC_STAGES-1];
  assign y_out     = y_r[CORDIC_STAGES-1];
  assign tag_out   = t_r[CORDIC_STAGES-1];
  assign out_valid = v_r[CORDIC_STAGES-1];

endmodule

// ----- src/gcd_isqrt.sv -----
module gcd_isqrt
  import gcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  sq_t               v_in [SQ_LANES],
  output logic [ROOT_W-1:0] root [SQ_LANES],
  output logic              out_valid
);

  sq_t  v_r [SQRT_STEPS][SQ_LANES];
  sq_t  r_r [SQRT_STEPS][SQ_LANES];
  logic ok_r [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_st
    localparam sq_t BIT = sq_t'(1) << (SQRT_TOP - 2 * s);
    sq_t  vi [SQ_LANES];
    sq_t  ri [SQ_LANES];
    sq_t  tr [SQ_LANES];
    logic oki;

    if (s == 0) begin : g_src
      assign vi  = v_in;
      assign ri  = '{default: '0};
      assign oki = in_valid;
    end else begin : g_src
      assign vi  = v_r[s-1];
      assign ri  = r_r[s-1];
      assign oki = ok_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < SQ_LANES; l++) begin
        tr[l] = ri[l] + BIT;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ok_r[s] <= 1'b0;
      end else if (en) begin
        ok_r[s] <= oki;
      end
    end

    // One result bit per stage.
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < SQ_LANES; l++) begin
          if (vi[l] >= tr[l]) begin
            v_r[s][l] <= vi[l] - tr[l];
            r_r[s][l] <= (ri[l] >> 1) + BIT;
          end else begin
            v_r[s][l] <= vi[l];
            r_r[s][l] <= ri[l] >> 1;
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < SQ_LANES; l++) begin
      root[l] = r_r[SQRT_STEPS-1][l][ROOT_W-1:0];
    end
  end

  assign out_valid = ok_r[SQRT_STEPS-1];

endmodule

// ----- src/gcd_cordic_vec.sv -----
module gcd_cordic_vec
  import gcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] ra,
  input  logic [ROOT_W-1:0] rb,
  output ang_t              z_out,
  output logic              out_valid
);

  vec_t x_r [CORDIC_STAGES];
  vec_t y_r [CORDIC_STAGES];
  ang_t z_r [CORDIC_STAGES];
  logic zf_r [CORDIC_STAGES];
  logic v_r [CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
    localparam ang_t ATAN = atan_q40(i);
    vec_t xi;
    vec_t yi;
    ang_t zi;
    logic zfi;
    logic vi;

    if (i == 0) begin : g_src
      assign xi  = vec_t'(rb);
      assign yi  = vec_t'(ra);
      assign zi  = '0;
      assign zfi = (ra == '0);
      assign vi  = in_valid;
    end else begin : g_src
      assign xi  = x_r[i-1];
      assign yi  = y_r[i-1];
      assign zi  = z_r[i-1];
      assign zfi = zf_r[i-1];
      assign vi  = v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vi;
      end
    end

    // Drive y toward zero and collect the angle.
    always_ff @(posedge clk) begin
      if (en) begin
        zf_r[i] <= zfi;
        if (!yi[VEC_W-1]) begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN;
        end else begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN;
        end
      end
    end
  end

  // A zero haversine root means no angle; a negative angle is clamped.
  assign z_out = (zf_r[CORDIC_STAGES-1] || z_r[CORDIC_STAGES-1][ANG_W-1]) ?
                 '0 : z_r[CORDIC_STAGES-1];
  assign out_valid = v_r[CORDIC_STAGES-1];

endmodule

// ----- src/great_circle_distance_top.sv -----
// Great-circle distance of two points by the haversine formula.
//
// Input stream (s_*): one request carries two points, latitude and longitude in
// signed units of 1e-7 degree. Output stream (m_*): one distance per request,
// in thousandths of a kilometer or of a meter, saturated to 35 bits.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr at a clock edge;
// index 0 is the Earth radius in meters, index 1 the unit (bit 0: 0 km, 1 m).
// Write registers only while no request is in flight.
//
// Throughput is one request per cycle except while the pipeline holds. From acceptance
// to m_tvalid a request passes two front stages, 32 rotation CORDIC stages, four haversine
// multiply stages, 31 square-root stages, 32 vectoring CORDIC stages, two
// scaling stages and the output register. The CORDIC and root depths make up most of it.
//
// Reset clears all valid bits and loads the register reset values (radius
// 6371000 m, kilometers). When the receiver stalls, the result waits in the
// output register; the pipeline keeps moving and taking requests until a
// second result reaches its last stage, then the whole pipeline holds.
module great_circle_distance_top
  import gcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // distance[34:0]
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [23:0]  cfg_wdata
);

  // Configuration registers.
  logic [23:0] earth_radius_m;
  logic        unit_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_m <= RADIUS_RESET;
      unit_select    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EARTH_RADIUS: earth_radius_m <= cfg_wdata;
        REG_UNIT_SELECT:  unit_select    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The pipeline holds only when the output is full, not taken, and the last
  // stage has a result to hand over. Bubbles ahead of that are squeezed out.
  logic en;
  logic fin_valid;
  logic [34:0] distance;

  assign en       = !(m_tvalid && !m_tready && fin_valid);
  assign s_tready = en;

  // Front end: half-angle differences and latitudes in half-units, reduced.
  logic signed [30:0] lat_a, lat_b;
  logic signed [31:0] lon_a, lon_b;
  logic signed [33:0] d_lat, d_lon, l2a, l2b, lat_a_x, lat_b_x;

  assign lat_a = s_tdata[30:0];
  assign lon_a = s_tdata[62:31];
  assign lat_b = s_tdata[93:63];
  assign lon_b = s_tdata[125:94];

  // Wrap a half angle into [-90, 90) degrees.
  function automatic logic signed [31:0] wrap_half(input logic signed [33:0] d);
    logic signed [33:0] r;
    r = d;
    if (d >= QUARTER_TURN) r = d - HALF_TURN;
    else if (d < -QUARTER_TURN) r = d + HALF_TURN;
    return r[31:0];
  endfunction

  // Fold a doubled latitude into [-90, 90] degrees; the top bit flags a
  // cosine sign flip.
  function automatic logic [32:0] fold_lat(input logic signed [33:0] d);
    logic signed [33:0] r;
    logic               neg;
    r   = d;
    neg = 1'b0;
    if (d > QUARTER_TURN) begin
      r   = d - HALF_TURN;
      neg = 1'b1;
    end else if (d < -QUARTER_TURN) begin
      r   = d + HALF_TURN;
      neg = 1'b1;
    end
    return {neg, r[31:0]};
  endfunction

  always_comb begin
    lat_a_x = lat_a;
    lat_b_x = lat_b;
    d_lat   = lat_b_x - lat_a_x;
    d_lon   = lon_b - lon_a;
    l2a     = lat_a_x <<< 1;
    l2b     = lat_b_x <<< 1;
  end

  // Stage 1: reduced angles. Lanes: 0 latitude half difference, 1 longitude
  // half difference, 2 first latitude, 3 second latitude.
  logic signed [31:0] h_q [NLANE];
  logic [NLANE-1:0]   neg_q;
  logic               v1;
  logic [32:0]        fa, fb;

  assign fa = fold_lat(l2a);
  assign fb = fold_lat(l2b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_q[0] <= wrap_half(d_lat);
      h_q[1] <= wrap_half(d_lon);
      h_q[2] <= fa[31:0];
      h_q[3] <= fb[31:0];
      neg_q  <= {fb[32], fa[32], 2'b00};
    end
  end

  // Stage 2: scale to radians in Q40 (the shift is taken in the wiring).
  logic signed [65:0] prod_q [NLANE];
  logic [NLANE-1:0]   neg2_q;
  logic               v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_q <= neg_q;
      for (int l = 0; l < NLANE; l++) begin
        prod_q[l] <= h_q[l] * ANG_SCALE_S;
      end
    end
  end

  ang_t             rot_z [NLANE];
  vec_t             rot_x [NLANE];
  vec_t             rot_y [NLANE];
  logic [NLANE-1:0] rot_tag;
  logic             rot_valid;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      rot_z[l] = prod_q[l][ANG_W+21:22];
    end
  end

  gcd_cordic_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .z_in      (rot_z),
    .tag_in    (neg2_q),
    .x_out     (rot_x),
    .y_out     (rot_y),
    .tag_out   (rot_tag),
    .out_valid (rot_valid)
  );

  // Haversine term: sin^2 of the latitude half difference plus the cosine
  // product times sin^2 of the longitude half difference.
  vec_t c1, c2;
  assign c1 = rot_tag[2] ? -rot_x[2] : rot_x[2];
  assign c2 = rot_tag[3] ? -rot_x[3] : rot_x[3];

  logic signed [67:0] p1_q, pc_q, p2_q, p1b_q, q_q;
  logic signed [68:0] sum_q;
  logic               v4, v5, v6, v7;
  sq_t                sq_in [SQ_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= rot_valid;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_q  <= rot_y[0] * rot_y[0];
      pc_q  <= c1 * c2;
      p2_q  <= rot_y[1] * rot_y[1];
      p1b_q <= p1_q;
      q_q   <= $signed(pc_q[63:30]) * $signed(p2_q[63:30]);
      sum_q <= p1b_q + q_q;
      // Clamp into [0, 1] and form 1 - a alongside.
      if (sum_q[68]) begin
        sq_in[0] <= '0;
        sq_in[1] <= sq_t'(ONE_Q60);
      end else if (sum_q > ONE_Q60) begin
        sq_in[0] <= sq_t'(ONE_Q60);
        sq_in[1] <= '0;
      end else begin
        sq_in[0] <= sq_t'(sum_q);
        sq_in[1] <= sq_t'(ONE_Q60 - sum_q);
      end
    end
  end

  logic [ROOT_W-1:0] roots [SQ_LANES];
  logic              sq_valid;

  gcd_isqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .v_in      (sq_in),
    .root      (roots),
    .out_valid (sq_valid)
  );

  ang_t vec_z;
  logic vec_valid;

  gcd_cordic_vec u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .ra        (roots[0]),
    .rb        (roots[1]),
    .z_out     (vec_z),
    .out_valid (vec_valid)
  );

  // Scaling: central angle c = 2z in Q40, times the radius in the chosen
  // unit, with the angle split in a high and a low part, each rounded.
  logic [ANG_W:0] c_q;
  logic [33:0]    m_q;
  logic [58:0]    mhi_q;
  logic [53:0]    mlo_q;
  logic           v8;
  logic [54:0]    lo_rnd;
  logic [59:0]    tot;
  logic [39:0]    dist_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8        <= 1'b0;
      fin_valid <= 1'b0;
    end else if (en) begin
      v8        <= vec_valid;
      fin_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_q   <= {vec_z[ANG_W-1:0], 1'b0};
      m_q   <= unit_select ? 34'(earth_radius_m) * KM_TO_M : 34'(earth_radius_m);
      mhi_q <= m_q * c_q[ANG_W:20];
      mlo_q <= m_q * c_q[19:0];
    end
  end

  always_comb begin
    lo_rnd    = ({1'b0, mlo_q} + 55'd524288) >> 20;
    tot       = 60'(mhi_q) + 60'(lo_rnd) + 60'd524288;
    dist_full = tot[59:20];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((!m_tvalid || m_tready) && fin_valid) begin
      distance <= (dist_full > DIST_MAX) ? DIST_MAX[34:0] : dist_full[34:0];
    end
  end

  assign m_tdata = {5'b0, distance};

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked while output register is empty");

  // A request taken enters the first stage; an idle cycle leaves a bubble.
  a_front_valid: assert property (@(posedge clk)
    (!rst && s_tready) |=> (v1 == $past(s_tvalid)))
    else $error("front stage valid does not follow the input handshake");

  // While the pipeline holds, the result in the last stage stays there.
  a_hold_keeps_last: assert property (@(posedge clk)
    (!rst && !s_tready) |=> fin_valid)
    else $error("last stage result lost during a hold");

endmodule

// ----- sim/tb_great_circle_distance_top.sv -----
module tb_great_circle_distance_top;
  import gcd_pkg::*;

  // Each request in this bench carries two points packed the way s_tdata wants them.
  typedef struct packed {
    logic [31:0] lon_b;
    logic [30:0] lat_b;
    logic [31:0] lon_a;
    logic [30:0] lat_a;
  } point_pair_t;

  localparam longint HALF_TURN_HU  = 64'sd3600000000;
  localparam longint FULL_TURN_HU  = 64'sd7200000000;
  localparam longint QTR_TURN_HU   = 64'sd1800000000;
  localparam longint ANG_SCALE_L   = 64'sd4024455254;
  localparam longint UNIT_Q60      = 64'sd1 << 60;
  localparam longint unsigned QPI_Q62 = 64'd3622009729038561421;
  localparam int     N_STAGES      = 32;
  localparam int     PIPE_LATENCY  = 104;
  localparam int     HOLD_CYCLES   = 300;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_addr = REG_EARTH_RADIUS;
  logic [23:0]  cfg_wdata = '0;

  great_circle_distance_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // The bench keeps its own copy of the two registers.
  logic [23:0] radius_m = 24'd6371000;
  logic        unit_meters = 1'b0;

  longint         atan_tab[N_STAGES];
  point_pair_t    point_pairs[$];
  logic [34:0]    distance_due[$];
  int             errors = 0;
  longint         cycle = 0;
  bit             hold_start = 1'b0;
  bit             hold_done = 1'b0;
  int             hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  // Floor square root of a 64-bit value.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Wrap v into [-period/2, period/2).
  function automatic longint wrap_angle(input longint v, input longint period);
    longint r;
    r = v % period;
    if (r >= period / 2) r = r - period;
    if (r < -(period / 2)) r = r + period;
    return r;
  endfunction

  // Rotation CORDIC on a half-unit angle, returning cosine and sine in Q30.
  function automatic void rotate_hu(input longint hu, output longint cos_q, output longint sin_q);
    longint x, y, z, dx, dy;
    x = 64'sd652032874;
    y = 0;
    z = (hu * ANG_SCALE_L) >>> 22;
    for (int i = 0; i < N_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_tab[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_tab[i];
      end
    end
    cos_q = x;
    sin_q = y;
  endfunction

  function automatic longint half_sine(input longint hu);
    longint c, s;
    rotate_hu(wrap_angle(hu, HALF_TURN_HU), c, s);
    return s;
  endfunction

  // Cosine of a latitude; beyond +-90 degrees it folds back with the sign flipped.
  function automatic longint lat_cosine(input longint lat);
    longint r, c, s;
    bit flip;
    r = wrap_angle(2 * lat, FULL_TURN_HU);
    flip = 1'b0;
    if (r > QTR_TURN_HU) begin
      r = r - HALF_TURN_HU; flip = 1'b1;
    end else if (r < -QTR_TURN_HU) begin
      r = r + HALF_TURN_HU; flip = 1'b1;
    end
    rotate_hu(r, c, s);
    return flip ? -c : c;
  endfunction

  // Expected distance for one pair under the current register copy.
  function automatic logic [34:0] sphere_distance(input point_pair_t p);
    longint la, oa, lb, ob, s1, s2, c1, c2, hav, x, y, z, dx, dy;
    longint unsigned ra, rb, ang, m, hi, lo, dist_val;
    la = longint'($signed(p.lat_a));
    oa = longint'($signed(p.lon_a));
    lb = longint'($signed(p.lat_b));
    ob = longint'($signed(p.lon_b));
    s1 = half_sine(lb - la);
    s2 = half_sine(ob - oa);
    c1 = lat_cosine(la);
    c2 = lat_cosine(lb);
    hav = s1 * s1 + ((c1 * c2) >>> 30) * ((s2 * s2) >>> 30);
    if (hav < 0) hav = 0;
    if (hav > UNIT_Q60) hav = UNIT_Q60;
    ra = floor_root(hav);
    rb = floor_root(UNIT_Q60 - hav);
    z = 0;
    // A zero root means the points coincide, so the angle stays exactly zero.
    if (ra != 0) begin
      x = rb;
      y = ra;
      for (int i = 0; i < N_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx; y = y - dy; z = z + atan_tab[i];
        end else begin
          x = x - dx; y = y + dy; z = z - atan_tab[i];
        end
      end
      if (z < 0) z = 0;
    end
    ang = z * 2;
    m = radius_m;
    if (unit_meters) m = m * 1000;
    hi = ang >> 20;
    lo = ang & 64'hFFFFF;
    dist_val = (m * hi + ((m * lo + (64'd1 << 19)) >> 20) + (64'd1 << 19)) >> 20;
    if (dist_val > 64'h7_FFFF_FFFF) dist_val = 64'h7_FFFF_FFFF;
    return dist_val[34:0];
  endfunction

  // Driver: offers queued requests, idling now and then except in a quiet window.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        distance_due.push_back(sphere_distance(point_pair_t'(s_tdata[125:0])));
      end
      if (!s_tvalid || s_tready) begin
        if (point_pairs.size() > 0 &&
            ((cycle > 20 && cycle < 170) || $urandom_range(99) >= 10)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= 128'(point_pairs.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, one long hold-off while requests keep coming,
  // and a quiet window at a different place than the sender's.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_start && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= (cycle > 120 && cycle < 260) || ($urandom_range(99) >= 10);
    end
  end

  // Monitor: every accepted result must match the oldest expected distance.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (distance_due.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $realtime, m_tdata);
        errors <= errors + 1;
      end else begin
        if (m_tdata !== {5'b0, distance_due[0]}) begin
          $display("%0t: distance mismatch, expected %0d actual %0d",
                   $realtime, distance_due[0], m_tdata);
          errors <= errors + 1;
        end
        void'(distance_due.pop_front());
      end
    end
  end

  task automatic add_pair(input longint la, input longint oa, input longint lb, input longint ob);
    point_pair_t p;
    p.lat_a = la[30:0];
    p.lon_a = oa[31:0];
    p.lat_b = lb[30:0];
    p.lon_b = ob[31:0];
    point_pairs.push_back(p);
  endtask

  task automatic add_random_pairs(input int count);
    longint la, oa;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      la = longint'($urandom_range(1800000000)) - 900000000;
      oa = longint'($urandom_range(3600000000)) - 1800000000;
      if (pick < 65) begin
        add_pair(la, oa, longint'($urandom_range(1800000000)) - 900000000,
                 longint'($urandom_range(3600000000)) - 1800000000);
      end else if (pick < 85) begin
        // Nearby points, where the haversine term is tiny.
        add_pair(la, oa, la + longint'($urandom_range(2000)) - 1000,
                 oa + longint'($urandom_range(2000)) - 1000);
      end else begin
        // Raw bit patterns, out-of-range angles included.
        add_pair(longint'($signed(31'($urandom))), longint'($signed($urandom)),
                 longint'($signed(31'($urandom))), longint'($signed($urandom)));
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_EARTH_RADIUS) radius_m = val;
    else unit_meters = val[0];
  endtask

  // Wait for the pipe to drain, then let it settle before the next write.
  task automatic drain();
    while (point_pairs.size() > 0 || s_tvalid || distance_due.size() > 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    longint unsigned acc, t;
    int e;
    for (int i = 0; i < N_STAGES; i++) begin
      if (i == 0) begin
        atan_tab[i] = (QPI_Q62 + (64'd1 << 21)) >> 22;
      end else begin
        acc = 0;
        for (int k = 0; ; k++) begin
          e = i * (2 * k + 1);
          if (e > 62) break;
          t = (64'd1 << (62 - e)) / longint'(2 * k + 1);
          if (k % 2 == 1) acc = acc - t;
          else acc = acc + t;
        end
        atan_tab[i] = (acc + (64'd1 << 21)) >> 22;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with the reset registers: coincident points, poles,
    // date line, field extremes, out-of-range angles and one-unit steps.
    add_pair(0, 0, 0, 0);
    add_pair(900000000, 0, -900000000, 0);
    add_pair(0, -1800000000, 0, 1800000000);
    add_pair(0, 0, 0, 1800000000);
    add_pair(0, 0, 1, 0);
    add_pair(0, 0, 0, 1);
    add_pair(-900000000, -1800000000, 900000000, 1800000000);
    add_pair(1073741823, 2147483647, -1073741824, -2147483648);
    add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
    add_pair(1073741823, 0, 1073741823, 0);
    add_pair(-1, -1, -1, -1);
    add_pair(515000000, -1270000, 407000000, -740000000);
    add_pair(900000000, 123456789, 900000000, -987654321);
    add_pair(0, 900000000, 0, -900000000);
    add_pair(450000000, 450000000, -450000000, -1350000000);
    add_pair(123, 456, 124, 457);
    add_pair(-1073741824, 0, 1073741823, 0);
    add_pair(899999999, 1799999999, -899999999, -1799999999);
    add_random_pairs(140);
    drain();

    write_reg(REG_UNIT_SELECT, 24'hABCDE1);
    write_reg(REG_EARTH_RADIUS, 24'd6371000);
    hold_start = 1'b1;
    add_random_pairs(170);
    drain();

    write_reg(REG_EARTH_RADIUS, 24'd1);
    write_reg(REG_UNIT_SELECT, 24'h000000);
    add_random_pairs(140);
    drain();

    // Largest radius in meters drives the distance into saturation.
    write_reg(REG_EARTH_RADIUS, 24'hFFFFFF);
    write_reg(REG_UNIT_SELECT, 24'h000001);
    add_pair(900000000, 0, -900000000, 0);
    add_random_pairs(140);
    drain();

    write_reg(REG_EARTH_RADIUS, 24'd0);
    add_random_pairs(120);
    drain();

    write_reg(REG_EARTH_RADIUS, 24'd10000000);
    write_reg(REG_UNIT_SELECT, 24'hFFFFFE);
    add_random_pairs(140);
    drain();

    write_reg(REG_EARTH_RADIUS, 24'd6378137);
    write_reg(REG_UNIT_SELECT, 24'h000001);
    add_random_pairs(140);
    drain();

    if (errors == 0 && distance_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
